// ----- rtl/sharp_pkg.sv -----
// ----------------------------------------------------------------------------
// Sharpen stencil package
// Shared widths, register indexes, item codes and the classification flags
// that travel from the front end to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package sharp_pkg;

	localparam int DATA_W    = 8;
	localparam int ROW_W     = 12;
	localparam int COL_W     = 13;
	localparam int CCNT_W    = 3;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;

	localparam int DEF_MAX_WIDTH    = 2048;
	localparam int DEF_MAX_CHANNELS = 4;
	localparam int QUEUE_DEPTH      = 4;

	localparam int RST_CHANNELS = 3;
	localparam int RST_WIDTH    = 640;
	localparam logic [CFG_W-1:0] RST_HEIGHT = 12'd480;
	localparam logic [CFG_W-1:0] MIN_WIDTH  = 12'd3;
	localparam logic [CFG_W-1:0] MIN_HEIGHT = 12'd3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CHANNEL_COUNT = 2'd0,
		REG_IMAGE_WIDTH   = 2'd1,
		REG_IMAGE_HEIGHT  = 2'd2
	} sharp_reg_t;

	localparam logic CMD_PIXEL = 1'b0;
	localparam logic CMD_FLUSH = 1'b1;

	// Classification of one stream byte, decided by the front end.
	typedef struct packed {
		logic emit;      // byte releases a result
		logic interior;  // released result is a full stencil position
		logic fend;      // released result is the last byte of the frame
	} sharp_flags_t;

endpackage

`default_nettype wire

// ----- rtl/sharp_in_if.sv -----
// ----------------------------------------------------------------------------
// Sharpen input channel
// Valid/ready channel that carries one command and one channel byte.
// ----------------------------------------------------------------------------
`default_nettype none

interface sharp_in_if import sharp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic              cmd;
	logic [DATA_W-1:0] sample;

	modport source (output valid, output cmd, output sample, input ready);
	modport sink   (input valid, input cmd, input sample, output ready);
endinterface

`default_nettype wire

// ----- rtl/sharp_out_if.sv -----
// ----------------------------------------------------------------------------
// Sharpen output channel
// Valid/ready channel that carries one result byte and its frame position.
// ----------------------------------------------------------------------------
`default_nettype none

interface sharp_out_if import sharp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [DATA_W-1:0] result_byte;
	logic [ROW_W-1:0]  out_row;
	logic [COL_W-1:0]  out_col;
	logic              frame_end;

	modport source (output valid, output result_byte, output out_row, output out_col,
		output frame_end, input ready);
	modport sink   (input valid, input result_byte, input out_row, input out_col,
		input frame_end, output ready);
endinterface

`default_nettype wire

// ----- rtl/sharp_ram.sv -----
// ----------------------------------------------------------------------------
// Sharpen generic RAM
// One write port and one read port with registered, read-first data.
// ----------------------------------------------------------------------------
`default_nettype none

module sharp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sharp_queue.sv -----
// ----------------------------------------------------------------------------
// Sharpen item queue
// Small register FIFO that decouples the front end from the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module sharp_queue #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int PW = $clog2(DEPTH),
	localparam int CW = $clog2(DEPTH + 1)
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	input  wire logic [WIDTH-1:0] wdata,
	output logic                  full,
	input  wire logic             pop,
	output logic      [WIDTH-1:0] rdata,
	output logic                  empty
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PW-1:0]    wr_ptr_q;
	logic [PW-1:0]    rd_ptr_q;
	logic [CW-1:0]    count_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (count_q == CW'(DEPTH));
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/sharp_front.sv -----
// ----------------------------------------------------------------------------
// Sharpen front end
// Holds the configuration and the input position, drops flushes that arrive
// mid-frame, and classifies every kept byte before it enters the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module sharp_front import sharp_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS,
	localparam int AW    = $clog2(DEPTH),
	localparam int LW    = $clog2(DEPTH + 1)
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	sharp_in_if.sink                  pixels,
	input  wire logic                 queue_full,
	output logic                      push,
	output logic      [DATA_W-1:0]    item_x,
	output logic      [AW-1:0]        item_col,
	output logic      [AW-1:0]        item_uidx,
	output logic      [ROW_W-1:0]     item_row,
	output sharp_flags_t              item_flags,
	output logic      [CCNT_W-1:0]    chan_count
);

	localparam int RST_C = (RST_CHANNELS > MAX_CHANNELS) ? MAX_CHANNELS : RST_CHANNELS;
	localparam int RST_W = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
	localparam int WCMP_W = CFG_W + 2;

	logic [CCNT_W-1:0] chan_q;
	logic [CFG_W-1:0]  width_q;
	logic [CFG_W-1:0]  height_q;
	logic [LW-1:0]     len_q;
	logic [ROW_W:0]    in_row_q;
	logic [AW-1:0]     in_col_q;

	logic [CCNT_W-1:0] c_new;
	logic [CFG_W-1:0]  w_new;
	logic [CFG_W-1:0]  h_new;
	logic              cfg_hit;

	logic              accept;
	logic              in_frame;
	logic              drop;
	logic [LW-1:0]     col_l;
	logic [LW-1:0]     c_l;
	logic [LW-1:0]     col_inc;
	logic              col_ge_c;
	logic [LW-1:0]     uidx_l;
	logic [ROW_W:0]    h_ext;
	logic [ROW_W:0]    orow;

	// Register writes, clamped into range.
	always_comb begin
		if (cfg_wdata[CCNT_W-1:0] == '0) begin
			c_new = CCNT_W'(1);
		end else if (cfg_wdata[CCNT_W-1:0] > CCNT_W'(MAX_CHANNELS)) begin
			c_new = CCNT_W'(MAX_CHANNELS);
		end else begin
			c_new = cfg_wdata[CCNT_W-1:0];
		end
		if (cfg_wdata < MIN_WIDTH) begin
			w_new = MIN_WIDTH;
		end else if (WCMP_W'(cfg_wdata) > WCMP_W'(MAX_WIDTH)) begin
			w_new = CFG_W'(MAX_WIDTH);
		end else begin
			w_new = cfg_wdata;
		end
		h_new = (cfg_wdata < MIN_HEIGHT) ? MIN_HEIGHT : cfg_wdata;
	end

	assign cfg_hit = cfg_wr_en && (cfg_index == REG_CHANNEL_COUNT ||
		cfg_index == REG_IMAGE_WIDTH || cfg_index == REG_IMAGE_HEIGHT);

	// The row length is kept as a product so no multiplier sits in the item path.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chan_q   <= CCNT_W'(RST_C);
			width_q  <= CFG_W'(RST_W);
			height_q <= RST_HEIGHT;
			len_q    <= LW'(RST_C * RST_W);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_CHANNEL_COUNT: begin
					chan_q <= c_new;
					len_q  <= LW'(width_q) * LW'(c_new);
				end
				REG_IMAGE_WIDTH: begin
					width_q <= w_new;
					len_q   <= LW'(w_new) * LW'(chan_q);
				end
				REG_IMAGE_HEIGHT: begin
					height_q <= h_new;
				end
				default: begin
				end
			endcase
		end
	end

	assign accept       = pixels.valid && pixels.ready;
	assign pixels.ready = !queue_full;
	assign in_frame     = in_row_q < {1'b0, height_q};
	assign drop         = in_frame && (pixels.cmd == CMD_FLUSH);
	assign push         = accept && !drop;
	assign chan_count   = chan_q;

	// Position of the result that this byte releases, one row plus one pixel back.
	always_comb begin
		col_l    = LW'(in_col_q);
		c_l      = LW'(chan_q);
		col_inc  = col_l + LW'(1);
		col_ge_c = col_l >= c_l;
		uidx_l   = col_ge_c ? col_l - c_l : col_l + len_q - c_l;
		h_ext    = {1'b0, height_q};
		orow     = in_row_q - (col_ge_c ? (ROW_W + 1)'(1) : (ROW_W + 1)'(2));

		item_x    = in_frame ? pixels.sample : '0;
		item_col  = in_col_q;
		item_uidx = uidx_l[AW-1:0];
		item_row  = orow[ROW_W-1:0];

		item_flags.emit     = !(in_row_q == '0 || (in_row_q == (ROW_W + 1)'(1) && !col_ge_c));
		item_flags.interior = (orow != '0) && (orow < h_ext - 1'b1) &&
			(uidx_l >= c_l) && (uidx_l < len_q - c_l);
		item_flags.fend     = item_flags.emit && (orow >= h_ext - 1'b1) &&
			(uidx_l >= len_q - 1'b1);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (cfg_hit) begin
			in_row_q <= '0;
			in_col_q <= '0;
		end else if (push) begin
			if (item_flags.fend) begin
				in_row_q <= '0;
				in_col_q <= '0;
			end else if (col_inc >= len_q) begin
				in_col_q <= '0;
				in_row_q <= in_row_q + 1'b1;
			end else begin
				in_col_q <= in_col_q + 1'b1;
			end
		end
	end

`ifndef ASSERT_OFF
	a_fend_at_drain_end: assert property (@(posedge clk) disable iff (!arst_n)
		push && item_flags.fend |->
			in_row_q == h_ext + 1'b1 && col_l == c_l - 1'b1)
		else $error("frame end released away from the last drain position");

	a_row_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		in_row_q <= h_ext + 1'b1)
		else $error("input row ran past the drain row");

	a_drop_holds_position: assert property (@(posedge clk) disable iff (!arst_n)
		!cfg_hit && accept && drop |=> $stable(in_row_q) && $stable(in_col_q))
		else $error("dropped flush moved the input position");
`endif

endmodule

`default_nettype wire

// ----- rtl/sharp_back.sv -----
// ----------------------------------------------------------------------------
// Sharpen back end
// Runs the line stores and the pixel windows, evaluates the stencil and
// holds the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module sharp_back import sharp_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
	localparam int DEPTH = MAX_WIDTH * MAX_CHANNELS,
	localparam int AW    = $clog2(DEPTH)
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              queue_empty,
	output logic                   pop,
	input  wire logic [DATA_W-1:0] head_x,
	input  wire logic [AW-1:0]     head_col,
	input  wire logic [AW-1:0]     head_uidx,
	input  wire logic [ROW_W-1:0]  head_row,
	input  wire sharp_flags_t      head_flags,
	input  wire logic [CCNT_W-1:0] chan_count,
	sharp_out_if.source            results
);

	localparam int MW_DEPTH = 2 * MAX_CHANNELS + 1;
	localparam int NW_DEPTH = MAX_CHANNELS + 1;
	localparam int MW_IW    = $clog2(MW_DEPTH);
	localparam int NW_IW    = $clog2(NW_DEPTH);
	localparam int CMW_W    = CCNT_W + MW_IW;
	localparam int CNW_W    = CCNT_W + NW_IW;

	logic               v_s1;
	logic [DATA_W-1:0]  x_s1;
	logic [AW-1:0]      uidx_s1;
	logic [ROW_W-1:0]   row_s1;
	sharp_flags_t       flags_s1;

	logic               v_s2;
	logic [DATA_W-1:0]  up_s2;
	logic [AW-1:0]      uidx_s2;
	logic [ROW_W-1:0]   row_s2;
	sharp_flags_t       flags_s2;

	logic [DATA_W-1:0]  mw_q [MW_DEPTH];
	logic [DATA_W-1:0]  nw_q [NW_DEPTH];

	logic               out_v_q;
	logic [DATA_W-1:0]  out_byte_q;
	logic [ROW_W-1:0]   out_row_q;
	logic [COL_W-1:0]   out_col_q;
	logic               out_fend_q;

	logic [DATA_W-1:0]  mid_rdata;
	logic [DATA_W-1:0]  up_rdata;
	logic               adv1;
	logic               adv2;

	logic [CMW_W-1:0]   c_mw;
	logic [CMW_W-1:0]   c2_mw;
	logic [CNW_W-1:0]   c_nw;
	logic [DATA_W-1:0]  center;
	logic [DATA_W-1:0]  left;
	logic [DATA_W-1:0]  right;
	logic [DATA_W-1:0]  down;
	logic [DATA_W+2:0]  five_c;
	logic [DATA_W+1:0]  ring;
	logic [DATA_W+3:0]  diff;
	logic [DATA_W-1:0]  res;
	logic [COL_W+AW-1:0] col_ext;

	// Stage handshake: each stage moves when the next one is free or moving.
	assign adv2 = v_s2 && (!flags_s2.emit || !out_v_q || results.ready);
	assign adv1 = v_s1 && (!v_s2 || adv2);
	assign pop  = !queue_empty && (!v_s1 || adv1);

	// Middle line: read the byte of the previous row and store this one in its place.
	sharp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_mid_line (
		.clk   (clk),
		.we    (pop),
		.waddr (head_col),
		.wdata (head_x),
		.re    (pop),
		.raddr (head_col),
		.rdata (mid_rdata)
	);

	// Upper line: read early, rewritten with the center byte two stages later.
	sharp_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_up_line (
		.clk   (clk),
		.we    (adv2 && flags_s2.emit),
		.waddr (uidx_s2),
		.wdata (center),
		.re    (pop),
		.raddr (head_uidx),
		.rdata (up_rdata)
	);

	always_ff @(posedge clk) begin
		if (pop) begin
			x_s1     <= head_x;
			uidx_s1  <= head_uidx;
			row_s1   <= head_row;
			flags_s1 <= head_flags;
		end
		if (adv1) begin
			up_s2    <= up_rdata;
			uidx_s2  <= uidx_s1;
			row_s2   <= row_s1;
			flags_s2 <= flags_s1;
		end
		if (adv2 && flags_s2.emit) begin
			out_byte_q <= res;
			out_row_q  <= row_s2;
			out_col_q  <= col_ext[COL_W-1:0];
			out_fend_q <= flags_s2.fend;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
			for (int k = 0; k < MW_DEPTH; k++) begin
				mw_q[k] <= '0;
			end
			for (int k = 0; k < NW_DEPTH; k++) begin
				nw_q[k] <= '0;
			end
		end else begin
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (adv1) begin
				v_s1 <= 1'b0;
			end
			if (adv1) begin
				v_s2 <= 1'b1;
			end else if (adv2) begin
				v_s2 <= 1'b0;
			end
			if (adv2 && flags_s2.emit) begin
				out_v_q <= 1'b1;
			end else if (results.ready) begin
				out_v_q <= 1'b0;
			end
			if (adv1) begin
				mw_q[0] <= mid_rdata;
				for (int k = 1; k < MW_DEPTH; k++) begin
					mw_q[k] <= mw_q[k-1];
				end
				nw_q[0] <= x_s1;
				for (int k = 1; k < NW_DEPTH; k++) begin
					nw_q[k] <= nw_q[k-1];
				end
			end
		end
	end

	// Stencil taps. While an item sits in stage two the windows hold exactly
	// its neighborhood, since the next item can only shift when this one leaves.
	always_comb begin
		c_mw   = CMW_W'(chan_count);
		c2_mw  = c_mw << 1;
		c_nw   = CNW_W'(chan_count);
		center = mw_q[c_mw[MW_IW-1:0]];
		left   = mw_q[c2_mw[MW_IW-1:0]];
		right  = mw_q[0];
		down   = nw_q[c_nw[NW_IW-1:0]];

		five_c = {1'b0, center, 2'b00} + (DATA_W + 3)'(center);
		ring   = (DATA_W + 2)'(left) + (DATA_W + 2)'(right) +
			(DATA_W + 2)'(up_s2) + (DATA_W + 2)'(down);
		diff   = (DATA_W + 4)'(five_c) - (DATA_W + 4)'(ring);

		if (!flags_s2.interior) begin
			res = center;
		end else if (diff[DATA_W+3]) begin
			res = '0;
		end else if (diff[DATA_W+2:DATA_W] != '0) begin
			res = '1;
		end else begin
			res = diff[DATA_W-1:0];
		end

		col_ext = {{COL_W{1'b0}}, uidx_s2};
	end

	assign results.valid       = out_v_q;
	assign results.result_byte = out_byte_q;
	assign results.out_row     = out_row_q;
	assign results.out_col     = out_col_q;
	assign results.frame_end   = out_fend_q;

endmodule

`default_nettype wire

// ----- rtl/sharpen_3x3_stencil.sv -----
// ----------------------------------------------------------------------------
// 3x3 Laplacian sharpen, streaming
// Sharpens an interleaved 8-bit raster stream with the 5-point Laplacian
// stencil, passes the frame border through and drains the tail on flushes.
// ----------------------------------------------------------------------------
// The block takes one channel byte per clock and gives one result per clock
// once the pipe is full, as long as results are taken; the two line-store
// RAMs are each read once per byte and written at most once per byte. Each
// result comes out row_bytes + channel_count accepted items after its own
// byte (row_bytes = image_width * channel_count), then passes the queue, the
// line-store read stage and the stencil stage that loads the output register.
// The queue and the output register let the block keep taking bytes while a
// result waits to be taken, until the queue is full. After the last
// image byte of a frame, send row_bytes + channel_count more items (flushes or
// bytes, whose data is ignored) to drain the frame; a flush sent while the
// frame is still arriving is taken and dropped. Result byte 5*center minus the
// left, right, upper and lower byte of the same channel, clamped to 0..255,
// for interior positions; the first and last row and pixel column pass the
// input through. Any register write restarts the frame; write registers only
// when every result has been taken. The line stores are not cleared after
// reset: no clearing pass, the block accepts bytes from the first cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module sharpen_3x3_stencil import sharp_pkg::*; #(
	parameter int MAX_WIDTH    = DEF_MAX_WIDTH,
	parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	sharp_in_if.sink                  pixels,
	sharp_out_if.source               results
);

	localparam int DEPTH  = MAX_WIDTH * MAX_CHANNELS;
	localparam int AW     = $clog2(DEPTH);
	localparam int FLAG_W = $bits(sharp_flags_t);
	localparam int Q_W    = DATA_W + AW + AW + ROW_W + FLAG_W;

	// Front-end classification of the byte being transferred in.
	logic              push;
	logic [DATA_W-1:0] f_x;
	logic [AW-1:0]     f_col;
	logic [AW-1:0]     f_uidx;
	logic [ROW_W-1:0]  f_row;
	sharp_flags_t      f_flags;
	logic [CCNT_W-1:0] chan_count;

	// Queue between the two halves.
	logic              q_full;
	logic              q_empty;
	logic              pop;
	logic [Q_W-1:0]    q_wdata;
	logic [Q_W-1:0]    q_rdata;

	// Head of the queue as seen by the back end.
	logic [DATA_W-1:0] h_x;
	logic [AW-1:0]     h_col;
	logic [AW-1:0]     h_uidx;
	logic [ROW_W-1:0]  h_row;
	sharp_flags_t      h_flags;

	sharp_front #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.pixels     (pixels),
		.queue_full (q_full),
		.push       (push),
		.item_x     (f_x),
		.item_col   (f_col),
		.item_uidx  (f_uidx),
		.item_row   (f_row),
		.item_flags (f_flags),
		.chan_count (chan_count)
	);

	// Every kept byte goes through the queue, also the ones that release no
	// result: they still advance the line stores and the windows.
	assign q_wdata = {f_x, f_col, f_uidx, f_row, f_flags};

	sharp_queue #(.WIDTH(Q_W), .DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (pop),
		.rdata  (q_rdata),
		.empty  (q_empty)
	);

	assign {h_x, h_col, h_uidx, h_row, h_flags} = q_rdata;

	sharp_back #(.MAX_WIDTH(MAX_WIDTH), .MAX_CHANNELS(MAX_CHANNELS)) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.queue_empty (q_empty),
		.pop         (pop),
		.head_x      (h_x),
		.head_col    (h_col),
		.head_uidx   (h_uidx),
		.head_row    (h_row),
		.head_flags  (h_flags),
		.chan_count  (chan_count),
		.results     (results)
	);

endmodule

`default_nettype wire
